// ===== src/esc_pkg.sv =====
`timescale 1ns / 1ps

package esc_pkg;

    typedef enum logic [1:0] {
        OP_TEMP  = 2'd0,
        OP_PRESS = 2'd1,
        OP_HUM   = 2'd2
    } op_t;

    localparam int unsigned NUM_CAL    = 4;
    localparam int unsigned CAL_IDX_W  = 3;
    localparam int unsigned DIV_BITS   = 32;
    localparam int unsigned DIV_FIRST  = 10;
    localparam int unsigned POST_FIRST = DIV_FIRST + DIV_BITS;
    localparam int unsigned NUM_STAGES = POST_FIRST + 3;

    localparam logic [31:0] P_OFFSET  = 32'd64000;
    localparam logic [31:0] H_OFFSET  = 32'd76800;
    localparam logic [31:0] H_MAX     = 32'd419430400;
    localparam logic [31:0] P_SCALE   = 32'd3125;
    localparam logic [31:0] P_BASE    = 32'd1048576;
    localparam logic [31:0] H_BIAS_C  = 32'd2097152;
    localparam logic [31:0] H_RND_A   = 32'd16384;
    localparam logic [31:0] P_ONE     = 32'd32768;
    localparam logic [31:0] H_RND_C   = 32'd8192;
    localparam logic [31:0] T_RND     = 32'd128;

    // one item in flight, scratch fields are reused from stage to stage
    typedef struct packed {
        logic [1:0]  op;
        logic [19:0] rt;
        logic [19:0] rp;
        logic [15:0] rh;
        logic [31:0] tf;
        logic [31:0] tv;
        logic [31:0] hv;
        logic [31:0] x0;
        logic [31:0] x1;
        logic [31:0] x2;
        logic [31:0] x3;
        logic [31:0] x4;
        logic [31:0] x5;
        logic        dbl;
        logic        zero;
    } item_t;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        asr32 = 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] v);
        sx8 = {{24{v[7]}}, v};
    endfunction

endpackage

// ===== src/env_sensor_compensation.sv =====
`timescale 1ns / 1ps

// Compensates raw temperature, pressure and humidity conversions with 32 calibration
// bytes held in four 64-bit registers. One beat is taken every cycle unless the input
// is stalled; each result passes the pre arithmetic stages, the 32-stage bit-per-stage
// pressure divider and then the post arithmetic stages. All stages move
// together: while a result is stalled at the output the input is stalled too.
// Calibration writes are accepted at any time but are meant for an idle block.
module env_sensor_compensation
    import esc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           opcode,
    input  logic [19:0]          raw_temp,
    input  logic [19:0]          raw_press,
    input  logic [15:0]          raw_hum,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   value,
    output logic signed [31:0]   fine_temp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CAL_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    logic [63:0] cal_reg [NUM_CAL];

    item_t st_reg  [NUM_STAGES];
    item_t st_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic adv;

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    logic [31:0] k3_v1, k3_hv, k5_v1, k9_v, k42_p, k44_pres, k44_val;
    logic [32:0] dv_r;
    logic        dv_q;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CAL; i++)
            begin
                cal_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready && (cfg_index < CAL_IDX_W'(NUM_CAL)))
        begin
            cal_reg[cfg_index[1:0]] <= cfg_data;
        end
    end

    assign t1 = {16'd0, cal_reg[0][15:0]};
    assign t2 = sx16(cal_reg[0][31:16]);
    assign t3 = sx16(cal_reg[0][47:32]);
    assign p1 = {16'd0, cal_reg[0][63:48]};
    assign p2 = sx16(cal_reg[1][15:0]);
    assign p3 = sx16(cal_reg[1][31:16]);
    assign p4 = sx16(cal_reg[1][47:32]);
    assign p5 = sx16(cal_reg[1][63:48]);
    assign p6 = sx16(cal_reg[2][15:0]);
    assign p7 = sx16(cal_reg[2][31:16]);
    assign p8 = sx16(cal_reg[2][47:32]);
    assign p9 = sx16(cal_reg[2][63:48]);
    assign h1 = {24'd0, cal_reg[3][7:0]};
    assign h2 = sx16(cal_reg[3][23:8]);
    assign h3 = {24'd0, cal_reg[3][31:24]};
    assign h4 = (sx8(cal_reg[3][39:32]) << 4) | {28'd0, cal_reg[3][43:40]};
    assign h5 = (sx8(cal_reg[3][55:48]) << 4) | {28'd0, cal_reg[3][47:44]};
    assign h6 = sx8(cal_reg[3][63:56]);

    // whole pipeline moves unless the output beat is held
    assign adv      = !(vld_reg[NUM_STAGES-1] && out_stall);
    assign in_stall = !adv;
    assign vld_next = {vld_reg[NUM_STAGES-2:0], in_valid};

    always_comb
    begin
        k3_v1    = '0;
        k3_hv    = '0;
        k5_v1    = '0;
        k9_v     = '0;
        k42_p    = '0;
        k44_pres = '0;
        k44_val  = '0;
        dv_r     = '0;
        dv_q     = 1'b0;

        for (int k = 1; k < NUM_STAGES; k++)
        begin
            st_next[k] = st_reg[k-1];
        end

        // fine temperature products
        st_next[0]    = '0;
        st_next[0].op = opcode;
        st_next[0].rt = raw_temp;
        st_next[0].rp = raw_press;
        st_next[0].rh = raw_hum;
        st_next[0].x0 = ({15'd0, raw_temp[19:3]} - (t1 << 1)) * t2;
        st_next[0].x1 = ({16'd0, raw_temp[19:4]} - t1) * ({16'd0, raw_temp[19:4]} - t1);

        st_next[1].x1 = asr32(st_reg[0].x1, 12) * t3;

        st_next[2].tf = asr32(st_reg[1].x0, 11) + asr32(st_reg[1].x1, 14);

        // temperature result, first pressure and humidity products
        st_next[3].tv = asr32((st_reg[2].tf << 2) + st_reg[2].tf + T_RND, 8);
        k3_v1         = asr32(st_reg[2].tf, 1) - P_OFFSET;
        k3_hv         = st_reg[2].tf - H_OFFSET;
        st_next[3].x0 = asr32(k3_v1, 2) * asr32(k3_v1, 2);
        st_next[3].x1 = k3_v1 * p5;
        st_next[3].x2 = p2 * k3_v1;
        st_next[3].x3 = h5 * k3_hv;
        st_next[3].x4 = k3_hv * h6;
        st_next[3].x5 = k3_hv * h3;

        st_next[4].x0 = asr32(st_reg[3].x0, 11) * p6;
        st_next[4].x5 = p3 * asr32(st_reg[3].x0, 13);
        st_next[4].x3 = asr32(({12'd0, st_reg[3].rh, 4'd0} << 10) - (h4 << 20)
                              - st_reg[3].x3 + H_RND_A, 15);
        st_next[4].x4 = asr32(st_reg[3].x4, 10) * (asr32(st_reg[3].x5, 11) + P_ONE);

        st_next[5].x0 = asr32(st_reg[4].x0 + (st_reg[4].x1 << 1), 2) + (p4 << 16);
        k5_v1         = asr32(asr32(st_reg[4].x5, 3) + asr32(st_reg[4].x2, 1), 18);
        st_next[5].x1 = (P_ONE + k5_v1) * p1;
        st_next[5].x4 = (asr32(st_reg[4].x4, 10) + H_BIAS_C) * h2;

        st_next[6].x2 = asr32(st_reg[5].x1, 15);
        st_next[6].x0 = ((P_BASE - {12'd0, st_reg[5].rp}) - asr32(st_reg[5].x0, 12)) * P_SCALE;
        st_next[6].x3 = st_reg[5].x3 * asr32(st_reg[5].x4 + H_RND_C, 14);

        // divider setup: halve the work when the doubled numerator would overflow
        st_next[7].zero = (st_reg[6].x2 == '0);
        st_next[7].dbl  = !st_reg[6].x0[31];
        st_next[7].x0   = st_reg[6].x0[31] ? st_reg[6].x0 : (st_reg[6].x0 << 1);
        st_next[7].x1   = '0;
        st_next[7].x4   = asr32(st_reg[6].x3, 15) * asr32(st_reg[6].x3, 15);

        st_next[8].x4 = asr32(st_reg[7].x4, 7) * h1;

        k9_v = st_reg[8].x3 - asr32(st_reg[8].x4, 4);
        if (k9_v[31])
        begin
            k9_v = '0;
        end
        if (k9_v > H_MAX)
        begin
            k9_v = H_MAX;
        end
        st_next[9].hv = ((k9_v >> 12) * 32'd100) >> 10;

        // restoring divider, one quotient bit per stage
        for (int i = 0; i < DIV_BITS; i++)
        begin
            dv_r = {st_reg[DIV_FIRST+i-1].x1, st_reg[DIV_FIRST+i-1].x0[31]};
            dv_q = (dv_r >= {1'b0, st_reg[DIV_FIRST+i-1].x2});
            if (dv_q)
            begin
                dv_r = dv_r - {1'b0, st_reg[DIV_FIRST+i-1].x2};
            end
            st_next[DIV_FIRST+i].x1 = dv_r[31:0];
            st_next[DIV_FIRST+i].x0 = {st_reg[DIV_FIRST+i-1].x0[30:0], dv_q};
        end

        k42_p                  = st_reg[POST_FIRST-1].dbl ? st_reg[POST_FIRST-1].x0
                                                          : (st_reg[POST_FIRST-1].x0 << 1);
        st_next[POST_FIRST].x0 = k42_p;
        st_next[POST_FIRST].x1 = (k42_p >> 3) * (k42_p >> 3);
        st_next[POST_FIRST].x2 = (k42_p >> 2) * p8;

        st_next[POST_FIRST+1].x1 = p9 * (st_reg[POST_FIRST].x1 >> 13);

        k44_pres = st_reg[POST_FIRST+1].zero ? '0
                 : st_reg[POST_FIRST+1].x0 + asr32(asr32(st_reg[POST_FIRST+1].x1, 12)
                   + asr32(st_reg[POST_FIRST+1].x2, 13) + p7, 4);
        case (st_reg[POST_FIRST+1].op)
            OP_TEMP:  k44_val = st_reg[POST_FIRST+1].tv;
            OP_PRESS: k44_val = k44_pres;
            OP_HUM:   k44_val = st_reg[POST_FIRST+1].hv;
            default:  k44_val = '0;
        endcase
        st_next[POST_FIRST+2].x0 = k44_val;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    assign out_valid = vld_reg[NUM_STAGES-1];
    assign value     = $signed(st_reg[NUM_STAGES-1].x0);
    assign fine_temp = $signed(st_reg[NUM_STAGES-1].tf);

endmodule

// ===== src/esc_checker.sv =====
`timescale 1ns / 1ps

module esc_props
    import esc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] value,
    input logic signed [31:0] fine_temp
);

    // input is only held back by a held output beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output stall");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |-> !in_stall)
        else $error("input stalled while output drains");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output beat dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(value) && $stable(fine_temp)))
        else $error("output beat changed under stall");

endmodule

bind env_sensor_compensation esc_props u_esc_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .fine_temp (fine_temp)
);

// ===== sim/esc_checker.sv =====
`timescale 1ns / 1ps

module esc_checker
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [19:0] raw_temp,
    input  logic [19:0] raw_press,
    input  logic [15:0] raw_hum,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] value,
    input  logic [31:0] fine_temp,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [31:0] val;
        logic [31:0] tf;
    } comp_t;

    logic [63:0] cal [4];
    comp_t       expected_q [$];

    assign pending = expected_q.size();

    function automatic logic [31:0] sra(logic [31:0] x, int n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] cb(int i);
        return {24'd0, cal[(i >> 3) & 3][(i & 7) * 8 +: 8]};
    endfunction

    function automatic logic [31:0] u16(int i);
        return cb(i) | (cb(i + 1) << 8);
    endfunction

    function automatic logic [31:0] s16(int i);
        logic [31:0] v;
        v = u16(i);
        return {{16{v[15]}}, v[15:0]};
    endfunction

    function automatic logic [31:0] s8(int i);
        logic [31:0] v;
        v = cb(i);
        return {{24{v[7]}}, v[7:0]};
    endfunction

    function automatic logic [31:0] calc_fine(logic [31:0] adc);
        logic [31:0] t1, a, d, b;
        t1 = u16(0);
        a = (sra(adc, 3) - (t1 << 1)) * s16(2);
        d = sra(adc, 4) - t1;
        b = sra(d * d, 12) * s16(4);
        return sra(a, 11) + sra(b, 14);
    endfunction

    function automatic logic [31:0] calc_press(logic [31:0] tf, logic [31:0] adc);
        logic [31:0] v1, v2, q, p;
        v1 = sra(tf, 1) - 32'd64000;
        q = sra(v1, 2) * sra(v1, 2);
        v2 = sra(q, 11) * s16(16);
        v2 = v2 + ((v1 * s16(14)) << 1);
        v2 = sra(v2, 2) + (s16(12) << 16);
        v1 = sra(sra(s16(10) * sra(q, 13), 3) + sra(s16(8) * v1, 1), 18);
        v1 = sra((32'd32768 + v1) * u16(6), 15);
        if (v1 == 0)
            return 0;
        p = ((32'd1048576 - adc) - sra(v2, 12)) * 32'd3125;
        if (p < 32'h80000000)
            p = (p << 1) / v1;
        else
            p = (p / v1) * 2;
        v1 = sra(s16(22) * (((p >> 3) * (p >> 3)) >> 13), 12);
        v2 = sra((p >> 2) * s16(20), 13);
        return p + sra(v1 + v2 + s16(18), 4);
    endfunction

    function automatic logic [31:0] calc_hum(logic [31:0] tf, logic [31:0] adc);
        logic [31:0] h4, h5, v, a, b, c;
        h4 = (s8(28) << 4) | (cb(29) & 32'hF);
        h5 = (s8(30) << 4) | (cb(29) >> 4);
        v = tf - 32'd76800;
        a = sra(((adc << 14) - (h4 << 20) - (h5 * v)) + 32'd16384, 15);
        b = sra(v * s8(31), 10) * (sra(v * cb(27), 11) + 32'd32768);
        c = sra((sra(b, 10) + 32'd2097152) * s16(25) + 32'd8192, 14);
        v = a * c;
        v = v - sra(sra(sra(v, 15) * sra(v, 15), 7) * cb(24), 4);
        if (v[31])
            v = 0;
        if (v > 32'd419430400)
            v = 32'd419430400;
        return ((v >> 12) * 32'd100) >> 10;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        comp_t e, w;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                cal[i] = '0;
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected beat", value, 0);
                else
                begin
                    w = expected_q.pop_front();
                    if (value !== w.val)
                        report_mismatch("value", value, w.val);
                    if (fine_temp !== w.tf)
                        report_mismatch("fine_temp", fine_temp, w.tf);
                end
            end
            if (in_valid && !in_stall)
            begin
                e.tf = calc_fine({12'd0, raw_temp});
                case (opcode)
                    OP_TEMP:  e.val = sra(e.tf * 32'd5 + 32'd128, 8);
                    OP_PRESS: e.val = calc_press(e.tf, {12'd0, raw_press});
                    OP_HUM:   e.val = calc_hum(e.tf, {16'd0, raw_hum});
                    default:  e.val = 0;
                endcase
                expected_q.push_back(e);
            end
            if (cfg_valid && cfg_ready && cfg_index < 4)
                cal[cfg_index[1:0]] = cfg_data;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
    import esc_pkg::*;
();

    localparam int LATENCY = NUM_STAGES + 5;
    localparam int WATCHDOG = 2000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  opcode = 0;
    logic [19:0] raw_temp = 0;
    logic [19:0] raw_press = 0;
    logic [15:0] raw_hum = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [31:0] value;
    logic [31:0] fine_temp;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 0;
    logic [63:0] cfg_data = 0;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          calm = 0;

    always #5 clk = ~clk;

    env_sensor_compensation dut (.*);
    esc_checker u_checker (.*);

    // typical calibration, sane atmosphere
    localparam logic [63:0] CAL0 = 64'h8E5A_0032_6770_6E3E;
    localparam logic [63:0] CAL1 = 64'hFFF9_1C7A_D0B8_D6D0;
    localparam logic [63:0] CAL2 = 64'h1770_C0EC_FFF9_FFF9;
    localparam logic [63:0] CAL3 = 64'h1E32_0013_5000_164B;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("env_sensor_compensation test failed");
            $finish;
        end
    end

    // receiver stall bursts
    initial
    begin
        int n;
        n = 0;
        forever
        begin
            @(posedge clk);
            if (calm)
                out_stall <= 0;
            else if (n == 0)
            begin
                n = $urandom_range(0, 17);
                out_stall <= ($urandom_range(0, 2) == 0);
            end
            else
                n = n - 1;
        end
    end

    task automatic write_cal(int idx, logic [63:0] data);
        @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx[2:0];
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic send_meas(logic [1:0] op, logic [19:0] t, logic [19:0] p,
                             logic [15:0] h);
        in_valid <= 1;
        opcode <= op;
        raw_temp <= t;
        raw_press <= p;
        raw_hum <= h;
        do
            @(posedge clk);
        while (in_stall);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic load_cal(logic [63:0] c0, logic [63:0] c1, logic [63:0] c2,
                            logic [63:0] c3);
        drain();
        write_cal(0, c0);
        write_cal(1, c1);
        write_cal(2, c2);
        write_cal(3, c3);
        @(posedge clk);
    endtask

    task automatic random_phase(int n, bit realistic);
        logic [19:0] t;
        logic [19:0] p;
        for (int i = 0; i < n; i++)
        begin
            t = 20'($urandom);
            p = 20'($urandom);
            if (realistic && $urandom_range(0, 3) != 0)
            begin
                t = 20'($urandom_range(400000, 600000));
                p = 20'($urandom_range(250000, 450000));
            end
            send_meas(2'($urandom_range(0, 3)), t, p, 16'($urandom));
        end
        in_valid <= 0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // all-zero calibration gives a zero pressure divisor
        send_meas(OP_PRESS, 20'd519888, 20'd415148, 16'd0);
        send_meas(OP_TEMP, 20'd0, 20'd0, 16'd0);
        in_valid <= 0;

        load_cal(CAL0, CAL1, CAL2, CAL3);
        send_meas(OP_TEMP, 20'd519888, 20'd415148, 16'd30000);
        send_meas(OP_PRESS, 20'd519888, 20'd415148, 16'd30000);
        send_meas(OP_HUM, 20'd519888, 20'd415148, 16'd30000);
        send_meas(2'd3, 20'd519888, 20'd415148, 16'd30000);
        send_meas(OP_TEMP, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_meas(OP_PRESS, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_meas(OP_HUM, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_meas(OP_PRESS, 20'd0, 20'd0, 16'd0);
        send_meas(OP_HUM, 20'd0, 20'd0, 16'd0);
        send_meas(OP_HUM, 20'd519888, 20'd0, 16'hFFFF);
        send_meas(2'd3, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        in_valid <= 0;

        // sender holds off until the pipeline is empty
        drain();
        random_phase(300, 1);

        load_cal(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        random_phase(150, 0);

        load_cal({$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        random_phase(200, 0);

        load_cal(64'h8000_7FFF_8000_0000, 64'h8000_7FFF_8000_7FFF,
                 64'h7FFF_8000_7FFF_8000, 64'h807F_0F80_7FFF_FF00);
        random_phase(150, 0);

        load_cal(CAL0, CAL1, CAL2, CAL3);
        random_phase(250, 1);

        calm = 1;
        random_phase(150, 1);

        drain();
        if (fail_count == 0)
            $display("env_sensor_compensation test passed");
        else
            $display("env_sensor_compensation test failed");
        $finish;
    end

endmodule
